// ----- rtl/fwcrc_pkg.sv -----
// ----------------------------------------------------------------------------
// fwcrc_pkg: shared constants and functions for the image header/CRC checker
// Header layout, CRC32 constants, verdict codes, register map and the
// byte-wide reflected CRC32 update.
// ----------------------------------------------------------------------------
package fwcrc_pkg;

    // Bytes from the image start to the first code byte
    localparam int unsigned HEADER_BYTES = 256;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_SEED    = 32'h0D00_0721;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_INIT    = CRC_SEED ^ ALL_ONES;
    localparam logic [31:0] HDR_VERSION = 32'd1;

    // Offset of the last byte of each little-endian header word
    localparam logic [3:0] SIG_END = 4'd3;
    localparam logic [3:0] LEN_END = 4'd7;
    localparam logic [3:0] CRC_END = 4'd11;
    localparam logic [3:0] VER_END = 4'd15;

    // Last header byte offset, as a 32-bit counter value
    localparam logic [31:0] HDR_LAST = 32'(HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        RSN_OK      = 3'd0,
        RSN_SIG     = 3'd1,
        RSN_LENGTH  = 3'd2,
        RSN_VERSION = 3'd3,
        RSN_CRC     = 3'd4
    } t_reason;

    // APB register map (word index taken from paddr[2])
    localparam int unsigned ADDR_W = 3;
    localparam logic REG_SIG    = 1'b0;
    localparam logic REG_MAXLEN = 1'b1;

    localparam logic [31:0] MAXLEN_RESET = ALL_ONES;

    // One byte of reflected CRC32, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] acc_in,
                                             input logic [7:0]  b);
        logic [31:0] acc;
        acc = acc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/firmware_image_header_crc_checker_unit.sv -----
// ----------------------------------------------------------------------------
// firmware_image_header_crc_checker_unit: image header and CRC32 verifier
// Streams an image byte by byte, checks its header words and the CRC over
// the code area, and emits one verdict transaction per image.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one image byte per transaction in s_tdata[7:0]; s_tuser[0]
//   marks the first byte of an image and restarts checking at once, dropping
//   any check in progress. Bytes outside an image are ignored.
//   Master stream: one verdict transaction per image, when a header check
//   fails or after the last code byte: m_tuser = {fail_reason, image_valid},
//   m_tdata = computed CRC (zero for header failures).
//   APB: register 0 expected signature, register 1 max code length; write
//   only while the stream is idle. pready is tied high.
// Throughput and pipeline:
//   One byte per cycle while no verdict is waiting on m_tready. A byte is
//   held in the input register, then processed by a byte-wide CRC and a 32-bit
//   count/compare; its verdict is loaded into the result register behind m_tvalid.
// Reset:
//   Synchronous, active low; no verdict pending, checker waits for a first
//   byte, registers at their defaults.
// Stall:
//   While a verdict waits on m_tready, one more byte is taken into the input
//   register; then s_tready drops until the verdict transaction completes.
// ----------------------------------------------------------------------------
module firmware_image_header_crc_checker_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  logic [0:0]                   s_tuser,   // [0] first
    // master stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [31:0] computed_crc
    output logic [3:0]                   m_tuser,   // [0] image_valid, [3:1] fail_reason
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fwcrc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_CODE   = 2'd2
    } t_phase;

    // configuration
    logic [31:0] r_exp_sig;
    logic [31:0] r_max_len;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_first;

    // checker state
    t_phase      r_phase,     n_phase;
    logic [31:0] r_offset,    n_offset;
    logic [31:0] r_shift,     n_shift;
    logic [31:0] r_code_len,  n_code_len;
    logic [31:0] r_exp_crc,   n_exp_crc;
    logic [31:0] r_crc,       n_crc;

    // result register
    logic                 r_out_valid;
    logic                 r_out_ok;
    fwcrc_pkg::t_reason   r_out_reason;
    logic [31:0]          r_out_crc;

    logic                 n_verdict;
    logic                 n_ok;
    fwcrc_pkg::t_reason   n_reason;
    logic [31:0]          n_res_crc;

    logic        w_proc;
    logic        w_cfg_wr;

    // working values after a possible restart
    t_phase      v_phase;
    logic [31:0] v_offset;
    logic [31:0] v_shift;
    logic [31:0] v_crc;
    logic [31:0] v_next_off;
    logic [31:0] v_crc_new;
    logic [31:0] v_fin;

    assign w_proc   = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_proc;

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_crc;
    assign m_tuser  = {r_out_reason, r_out_ok};

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == fwcrc_pkg::REG_MAXLEN) ? r_max_len : r_exp_sig;

    always_comb begin
        n_phase    = r_phase;
        n_offset   = r_offset;
        n_shift    = r_shift;
        n_code_len = r_code_len;
        n_exp_crc  = r_exp_crc;
        n_crc      = r_crc;
        n_verdict  = 1'b0;
        n_ok       = 1'b0;
        n_reason   = fwcrc_pkg::RSN_OK;
        n_res_crc  = 32'd0;

        v_phase    = r_in_first ? PH_HEADER : r_phase;
        v_offset   = r_in_first ? 32'd0 : r_offset;
        v_shift    = r_in_first ? 32'd0 : r_shift;
        v_crc      = r_in_first ? fwcrc_pkg::CRC_INIT : r_crc;
        v_next_off = v_offset + 32'd1;
        v_crc_new  = fwcrc_pkg::crc_byte(v_crc, r_in_byte);
        v_fin      = v_crc_new ^ fwcrc_pkg::ALL_ONES;

        if (w_proc) begin
            n_phase  = v_phase;
            n_offset = v_offset;
            n_shift  = v_shift;
            n_crc    = v_crc;
            case (v_phase)
                PH_HEADER: begin
                    if (v_offset[31:4] == 28'd0) begin
                        n_shift = {r_in_byte, v_shift[31:8]};
                        case (v_offset[3:0])
                            fwcrc_pkg::SIG_END: begin
                                if (n_shift != r_exp_sig) begin
                                    n_verdict = 1'b1;
                                    n_reason  = fwcrc_pkg::RSN_SIG;
                                end
                            end
                            fwcrc_pkg::LEN_END: begin
                                n_code_len = n_shift;
                                if (n_shift == 32'd0 || n_shift > r_max_len) begin
                                    n_verdict = 1'b1;
                                    n_reason  = fwcrc_pkg::RSN_LENGTH;
                                end
                            end
                            fwcrc_pkg::CRC_END: begin
                                n_exp_crc = n_shift;
                            end
                            fwcrc_pkg::VER_END: begin
                                if (n_shift != fwcrc_pkg::HDR_VERSION) begin
                                    n_verdict = 1'b1;
                                    n_reason  = fwcrc_pkg::RSN_VERSION;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (n_verdict) begin
                        n_phase = PH_IDLE;
                    end else if (v_offset == fwcrc_pkg::HDR_LAST) begin
                        n_phase  = PH_CODE;
                        n_offset = 32'd0;
                    end else begin
                        n_offset = v_next_off;
                    end
                end
                PH_CODE: begin
                    n_crc    = v_crc_new;
                    n_offset = v_next_off;
                    // last code byte: compare against the header CRC
                    if (v_next_off >= r_code_len) begin
                        n_verdict = 1'b1;
                        n_phase   = PH_IDLE;
                        n_res_crc = v_fin;
                        if (v_fin == r_exp_crc) begin
                            n_ok     = 1'b1;
                            n_reason = fwcrc_pkg::RSN_OK;
                        end else begin
                            n_reason = fwcrc_pkg::RSN_CRC;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_sig    <= 32'd0;
            r_max_len    <= fwcrc_pkg::MAXLEN_RESET;
            r_in_valid   <= 1'b0;
            r_in_byte    <= 8'd0;
            r_in_first   <= 1'b0;
            r_phase      <= PH_IDLE;
            r_offset     <= 32'd0;
            r_shift      <= 32'd0;
            r_code_len   <= 32'd0;
            r_exp_crc    <= 32'd0;
            r_crc        <= fwcrc_pkg::CRC_INIT;
            r_out_valid  <= 1'b0;
            r_out_ok     <= 1'b0;
            r_out_reason <= fwcrc_pkg::RSN_OK;
            r_out_crc    <= 32'd0;
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == fwcrc_pkg::REG_MAXLEN) begin
                    r_max_len <= pwdata;
                end else begin
                    r_exp_sig <= pwdata;
                end
            end

            if (s_tvalid && s_tready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= s_tdata;
                r_in_first <= s_tuser[0];
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end

            r_phase    <= n_phase;
            r_offset   <= n_offset;
            r_shift    <= n_shift;
            r_code_len <= n_code_len;
            r_exp_crc  <= n_exp_crc;
            r_crc      <= n_crc;

            // load a verdict, else drop the one the receiver took
            if (w_proc && n_verdict) begin
                r_out_valid  <= 1'b1;
                r_out_ok     <= n_ok;
                r_out_reason <= n_reason;
                r_out_crc    <= n_res_crc;
            end else if (m_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    a_verdict_from_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_proc))
        else $error("verdict appeared without a processed byte");

    a_ok_means_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ok |-> r_out_reason == fwcrc_pkg::RSN_OK)
        else $error("valid image with a failure reason");

    a_header_fail_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_reason == fwcrc_pkg::RSN_SIG ||
                        r_out_reason == fwcrc_pkg::RSN_LENGTH ||
                        r_out_reason == fwcrc_pkg::RSN_VERSION) |-> r_out_crc == 32'd0)
        else $error("header failure carries a nonzero CRC");

    a_idle_after_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && n_verdict |=> r_phase == PH_IDLE)
        else $error("checker not idle after a verdict");

    a_stall_needs_full_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> r_in_valid && r_out_valid && !m_tready)
        else $error("input stalled with no pending work");

endmodule

// ----- tb/fwcrc_verdict_checker.sv -----
// ----------------------------------------------------------------------------
// fwcrc_verdict_checker: verdict predictor and scoreboard for the image checker
// Watches the APB writes and both stream channels, runs its own model of the
// header checks and the CRC over the code area, and compares every verdict
// transaction field by field with the oldest one it predicted.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fwcrc_verdict_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]                     i_s_tuser,   // [0] first
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [31:0]                    i_m_tdata,   // [31:0] computed_crc
    input  logic [3:0]                     i_m_tuser,   // [0] image_valid, [3:1] fail_reason
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [fwcrc_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [31:0]                    i_pwdata,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEADER,
        ST_CODE
    } t_stage;

    typedef struct packed {
        logic               valid;
        fwcrc_pkg::t_reason reason;
        logic [31:0]        crc;
    } t_verdict;

    t_verdict    verdicts_due[$];
    int          fail_cnt = 0;
    int          seen = 0;

    logic [31:0] exp_sig;
    logic [31:0] max_len;
    logic [32:0] offset;
    logic [31:0] hdr_word;
    logic [31:0] code_len;
    logic [31:0] want_crc;
    logic [31:0] crc_acc;
    t_stage      stage;

    assign o_fail_count = fail_cnt;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("verdict %0d: %s got %h want %h", seen, what, got, want);
        fail_cnt++;
    endtask

    // Advance the image model by one byte; queue a verdict when one is due
    task automatic track_image_byte(input logic [7:0] b, input logic first_flag);
        logic [32:0] o;
        logic [31:0] acc;
        t_verdict    v;
        logic        hit;
        hit = 1'b0;
        v.valid  = 1'b0;
        v.reason = fwcrc_pkg::RSN_OK;
        v.crc    = '0;
        if (first_flag) begin
            offset   = '0;
            hdr_word = '0;
            crc_acc  = fwcrc_pkg::CRC_INIT;
            stage    = ST_HEADER;
        end
        if (stage == ST_HEADER) begin
            o = offset;
            if (o < 33'd16) begin
                hdr_word = {b, hdr_word[31:8]};
                case (o[3:0])
                    fwcrc_pkg::SIG_END: begin
                        if (hdr_word != exp_sig) begin
                            hit      = 1'b1;
                            v.reason = fwcrc_pkg::RSN_SIG;
                        end
                    end
                    fwcrc_pkg::LEN_END: begin
                        code_len = hdr_word;
                        if (code_len == 32'd0 || code_len > max_len) begin
                            hit      = 1'b1;
                            v.reason = fwcrc_pkg::RSN_LENGTH;
                        end
                    end
                    fwcrc_pkg::CRC_END: want_crc = hdr_word;
                    fwcrc_pkg::VER_END: begin
                        if (hdr_word != fwcrc_pkg::HDR_VERSION) begin
                            hit      = 1'b1;
                            v.reason = fwcrc_pkg::RSN_VERSION;
                        end
                    end
                    default: ;
                endcase
            end
            if (!hit) begin
                if (o + 33'd1 >= 33'(fwcrc_pkg::HEADER_BYTES)) begin
                    stage  = ST_CODE;
                    offset = '0;
                end else begin
                    offset = o + 33'd1;
                end
            end
        end else if (stage == ST_CODE) begin
            acc = crc_acc ^ {24'd0, b};
            repeat (8) acc = (acc >> 1) ^ (fwcrc_pkg::CRC_POLY & {32{acc[0]}});
            crc_acc = acc;
            offset  = offset + 33'd1;
            if (offset >= {1'b0, code_len}) begin
                hit      = 1'b1;
                v.crc    = ~crc_acc;
                v.valid  = (v.crc == want_crc);
                v.reason = v.valid ? fwcrc_pkg::RSN_OK : fwcrc_pkg::RSN_CRC;
            end
        end
        if (hit) begin
            stage = ST_IDLE;
            verdicts_due.push_back(v);
        end
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            exp_sig  = '0;
            max_len  = fwcrc_pkg::MAXLEN_RESET;
            offset   = '0;
            hdr_word = '0;
            code_len = '0;
            want_crc = '0;
            crc_acc  = fwcrc_pkg::CRC_INIT;
            stage    = ST_IDLE;
            verdicts_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == fwcrc_pkg::REG_MAXLEN) begin
                    max_len = i_pwdata;
                end else begin
                    exp_sig = i_pwdata;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                track_image_byte(i_s_tdata, i_s_tuser[0]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (verdicts_due.size() == 0) begin
                    report("unexpected verdict, tdata", i_m_tdata, 32'd0);
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_m_tuser[0] !== want.valid) begin
                        report("image_valid", {31'd0, i_m_tuser[0]}, {31'd0, want.valid});
                    end
                    if (i_m_tuser[3:1] !== want.reason) begin
                        report("fail_reason", {29'd0, i_m_tuser[3:1]}, {29'd0, want.reason});
                    end
                    if (i_m_tdata !== want.crc) begin
                        report("computed_crc", i_m_tdata, want.crc);
                    end
                end
                seen++;
            end
        end
        o_pending <= verdicts_due.size();
    end

endmodule

// ----- tb/tb_firmware_image_header_crc_checker_unit.sv -----
// ----------------------------------------------------------------------------
// tb_firmware_image_header_crc_checker_unit: image checker testbench
// Streams directed and random images (good, bad CRC, bad signature, length
// and version, cut short, stray bytes) under several register settings with
// random idling on both streams; the checker module scores every verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_firmware_image_header_crc_checker_unit;

    localparam int LIMIT        = 600000;
    localparam int ITEMS_TARGET = 1300;
    localparam int QUIET_AFTER  = 1150;
    localparam int PHASES       = 5;

    typedef enum int {
        IMG_GOOD,
        IMG_BAD_CRC,
        IMG_BAD_SIG,
        IMG_BAD_LEN,
        IMG_BAD_VER,
        IMG_CUT
    } t_img_kind;

    logic                              i_clk;
    logic                              i_rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata = '0;
    logic [0:0]                        s_tuser = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [31:0]                       m_tdata;
    logic [3:0]                        m_tuser;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [fwcrc_pkg::ADDR_W-1:0]      paddr = '0;
    logic [31:0]                       pwdata = '0;
    logic [31:0]                       prdata;
    logic                              pready;

    int                                fail_count;
    int                                pending;
    int                                items = 0;
    int                                cycles = 0;
    int                                rdy_left = 0;
    logic                              quiet = 1'b0;
    logic [31:0]                       cur_sig = '0;
    logic [31:0]                       cur_max = fwcrc_pkg::ALL_ONES;

    firmware_image_header_crc_checker_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    fwcrc_verdict_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb_firmware_image_header_crc_checker_unit failed");
            $finish;
        end
    end

    // Verdict side: random stall and ready bursts, held high once quiet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rdy_left <= 0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (rdy_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                rdy_left <= $urandom_range(0, 12);
            end else begin
                m_tready <= 1'b1;
                rdy_left <= $urandom_range(1, 24);
            end
        end else begin
            rdy_left <= rdy_left - 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first_flag);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first_flag;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == fwcrc_pkg::REG_MAXLEN) begin
            cur_max = val;
        end else begin
            cur_sig = val;
        end
    endtask

    // Hold the stream until every predicted verdict is out and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_run(input logic [7:0] seq[$]);
        foreach (seq[i]) send_byte(seq[i], i == 0);
    endtask

    task automatic send_image(input t_img_kind kind);
        logic [31:0] sig_w, len_w, crc_w, ver_w, acc, lim, flip;
        logic [7:0]  b;
        logic [7:0]  img[$];
        logic [7:0]  code[$];
        int          n_code, n_send, k, j;
        sig_w = cur_sig;
        ver_w = fwcrc_pkg::HDR_VERSION;
        crc_w = $urandom;
        lim   = (cur_max > 32'd48) ? 32'd48 : cur_max;
        if (lim == 32'd0) begin
            len_w = 32'd0;
        end else if ($urandom_range(0, 7) == 0) begin
            len_w = $urandom_range(1, lim);
        end else begin
            len_w = $urandom_range(1, (lim > 32'd8) ? 32'd8 : lim);
        end
        case (kind)
            IMG_BAD_SIG: begin
                flip = $urandom;
                if (flip == 32'd0) flip = 32'd1 << $urandom_range(0, 31);
                sig_w = cur_sig ^ flip;
            end
            IMG_BAD_LEN: begin
                if (cur_max == fwcrc_pkg::ALL_ONES || $urandom_range(0, 2) == 0) begin
                    len_w = 32'd0;
                end else begin
                    case ($urandom_range(0, 2))
                        0: len_w = cur_max + 32'd1;
                        1: len_w = fwcrc_pkg::ALL_ONES;
                        default: len_w = $urandom_range(cur_max + 32'd1, fwcrc_pkg::ALL_ONES);
                    endcase
                end
            end
            IMG_BAD_VER: begin
                case ($urandom_range(0, 3))
                    0: ver_w = 32'd0;
                    1: ver_w = fwcrc_pkg::ALL_ONES;
                    2: ver_w = 32'd2;
                    default: ver_w = $urandom;
                endcase
                if (ver_w == fwcrc_pkg::HDR_VERSION) ver_w = 32'd0;
            end
            IMG_CUT: begin
                if (cur_max != 32'd0 && $urandom_range(0, 1) == 0) len_w = cur_max;
            end
            default: ;
        endcase
        n_code = (len_w > 32'd64) ? 64 : int'(len_w);
        acc = fwcrc_pkg::CRC_INIT;
        for (k = 0; k < n_code; k++) begin
            b = $urandom_range(0, 255);
            code.push_back(b);
            acc = acc ^ {24'd0, b};
            repeat (8) acc = acc[0] ? ((acc >> 1) ^ fwcrc_pkg::CRC_POLY) : (acc >> 1);
        end
        if (kind == IMG_GOOD || kind == IMG_BAD_CRC) crc_w = ~acc;
        if (kind == IMG_BAD_CRC) crc_w = crc_w ^ (32'd1 << $urandom_range(0, 31));
        for (j = 0; j < 4; j++) img.push_back(sig_w[8*j +: 8]);
        for (j = 0; j < 4; j++) img.push_back(len_w[8*j +: 8]);
        for (j = 0; j < 4; j++) img.push_back(crc_w[8*j +: 8]);
        for (j = 0; j < 4; j++) img.push_back(ver_w[8*j +: 8]);
        while (img.size() < fwcrc_pkg::HEADER_BYTES) begin
            img.push_back(8'($urandom_range(0, 255)));
        end
        foreach (code[i]) img.push_back(code[i]);
        case (kind)
            IMG_BAD_SIG: n_send = 4 + $urandom_range(0, 3);
            IMG_BAD_LEN: n_send = 8 + $urandom_range(0, 3);
            IMG_BAD_VER: n_send = 16 + $urandom_range(0, 3);
            IMG_CUT: begin
                if ($urandom_range(0, 1) == 0) begin
                    n_send = $urandom_range(1, 16);
                end else begin
                    n_send = $urandom_range(1, img.size() - 1);
                end
            end
            default: n_send = (len_w == 32'd0) ? 8 + $urandom_range(0, 3) : img.size();
        endcase
        for (k = 0; k < n_send; k++) send_byte(img[k], k == 0);
        items += n_send;
    endtask

    task automatic random_step();
        int r;
        int n_stray;
        r = $urandom_range(0, 99);
        if (r < 18) begin
            send_image(IMG_GOOD);
        end else if (r < 28) begin
            send_image(IMG_BAD_CRC);
        end else if (r < 43) begin
            send_image(IMG_BAD_SIG);
        end else if (r < 58) begin
            send_image(IMG_BAD_LEN);
        end else if (r < 73) begin
            send_image(IMG_BAD_VER);
        end else if (r < 85) begin
            send_image(IMG_CUT);
        end else begin
            // stray bytes: ignored when idle, else they extend a cut image
            n_stray = $urandom_range(1, 6);
            repeat (n_stray) send_byte(8'($urandom_range(0, 255)), 1'b0);
            items += n_stray;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        reg_write(fwcrc_pkg::REG_SIG, fwcrc_pkg::ALL_ONES);
        reg_write(fwcrc_pkg::REG_MAXLEN, 32'd5);
        drain();

        // one-byte image cut short, then signature, length and version fails
        send_run('{8'hA5});
        send_run('{8'h00, 8'h00, 8'h00, 8'h00});
        send_run('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_run('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h05, 8'h00, 8'h00, 8'h00,
                   8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'h00, 8'h00, 8'h00});
        drain();

        for (int p = 1; p <= PHASES; p++) begin
            case (p)
                1: begin
                    reg_write(fwcrc_pkg::REG_SIG, 32'd0);
                    reg_write(fwcrc_pkg::REG_MAXLEN, 32'd0);
                end
                2: begin
                    reg_write(fwcrc_pkg::REG_SIG, $urandom);
                    reg_write(fwcrc_pkg::REG_MAXLEN, 32'd1);
                end
                3: begin
                    reg_write(fwcrc_pkg::REG_SIG, $urandom);
                    reg_write(fwcrc_pkg::REG_MAXLEN, $urandom_range(2, 40));
                end
                4: begin
                    reg_write(fwcrc_pkg::REG_SIG, fwcrc_pkg::ALL_ONES);
                    reg_write(fwcrc_pkg::REG_MAXLEN, $urandom);
                end
                default: begin
                    reg_write(fwcrc_pkg::REG_SIG, $urandom);
                    reg_write(fwcrc_pkg::REG_MAXLEN, fwcrc_pkg::ALL_ONES);
                end
            endcase
            drain();
            if (p < PHASES) begin
                while (items < p * (ITEMS_TARGET / PHASES)) random_step();
            end else begin
                while (items < ITEMS_TARGET) begin
                    if (items >= QUIET_AFTER) quiet = 1'b1;
                    random_step();
                end
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb_firmware_image_header_crc_checker_unit passed");
        end else begin
            $display("tb_firmware_image_header_crc_checker_unit failed");
        end
        $finish;
    end

endmodule
